>>> rtl/pav_pkg.sv
package pav_pkg;

  localparam int unsigned RawW   = 16;
  localparam int unsigned CodeW  = 14;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned ScaleW = 16;
  localparam int unsigned ProdW  = CodeW + ScaleW;
  localparam int unsigned SqrtSteps = ProdW / 2;
  localparam int unsigned SqCntW = $clog2(SqrtSteps);
  localparam int unsigned SqRemW = SqrtSteps + 2;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_PRESSURE_ZERO = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_SCALE   = 1'b1;

  localparam logic [CodeW-1:0]  PressureZeroReset = 14'd8166;
  localparam logic [ScaleW-1:0] SpeedScaleReset   = 16'd28144;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PUPD = 8'b0000_0010,
    S_PDIV = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_SQRT = 8'b0001_0000,
    S_SUPD = 8'b0010_0000,
    S_SDIV = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

endpackage

>>> rtl/pav_ram.sv
module pav_ram import pav_pkg::*; #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 300
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write one word, read one word registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pav_div.sv
module pav_div import pav_pkg::*; #(
  parameter int unsigned DividendW = 25,
  parameter int unsigned DivisorW  = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DividendW);

  logic                 busy_q, done_q;
  logic [CntW-1:0]      cnt_q;
  logic [DividendW-1:0] quo_q;
  logic [DivisorW-1:0]  div_q, rem_q;
  logic [DivisorW:0]    trial, diff;
  logic                 ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, quo_q[DividendW-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DividendW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DividendW-2:0], ge};
      rem_q <= ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/pitot_airspeed_averager_top.sv
// channel | direction | handshake              | word
// in      | input     | in_valid_i/in_ready_o  | raw_reading_i
// out     | output    | out_valid_o/out_ready_i| mean_pressure_o, mean_airspeed_o
// cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
// Per word the bit-serial divider, DW = max(14 + clog2(PRESSURE_WINDOW),
// 16 + clog2(SPEED_WINDOW)) bits wide, runs twice and the square root
// takes 15 steps.
// Reset clears totals, slots and fill flags; ring contents are not cleared.
// A new word is taken only when the previous one has left the pipeline;
// a stalled result waits in the output register while the next word runs.
module pitot_airspeed_averager_top import pav_pkg::*; #(
  parameter int unsigned PRESSURE_WINDOW = 300,
  parameter int unsigned SPEED_WINDOW    = 300
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [RawW-1:0]    raw_reading_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CodeW-1:0]   mean_pressure_o,
  output logic [SpeedW-1:0]  mean_airspeed_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ScaleW-1:0]  cfg_data_i
);

  localparam int unsigned PaW  = $clog2(PRESSURE_WINDOW);
  localparam int unsigned SaW  = $clog2(SPEED_WINDOW);
  localparam int unsigned PcW  = $clog2(PRESSURE_WINDOW + 1);
  localparam int unsigned ScW  = $clog2(SPEED_WINDOW + 1);
  localparam int unsigned PtW  = CodeW + PaW;
  localparam int unsigned StW  = SpeedW + SaW;
  localparam int unsigned DvdW = (PtW > StW) ? PtW : StW;
  localparam int unsigned DvsW = (PcW > ScW) ? PcW : ScW;

  state_e state_q, state_d;

  logic [CodeW-1:0]  zero_q;
  logic [ScaleW-1:0] scale_q;

  logic [CodeW-1:0]  code_q;
  logic [PtW-1:0]    ptotal_q, ptotal_d;
  logic [PaW-1:0]    pslot_q;
  logic              pfilled_q;
  logic [StW-1:0]    stotal_q, stotal_d;
  logic [SaW-1:0]    sslot_q;
  logic              sfilled_q;
  logic [CodeW-1:0]  mp_q;
  logic [SpeedW-1:0] ms_q;
  logic [ProdW-1:0]  rad_q;
  logic [SqRemW-1:0] sq_rem_q;
  logic [SpeedW-1:0] root_q;
  logic [SqCntW-1:0] sq_cnt_q;
  logic              out_valid_q;
  logic [CodeW-1:0]  out_mp_q;
  logic [SpeedW-1:0] out_ms_q;

  logic [CodeW-1:0]  prd;
  logic [SpeedW-1:0] srd;
  logic [PcW-1:0]    pnext, pdivisor;
  logic [ScW-1:0]    snext, sdivisor;
  logic              div_start, div_busy, div_done;
  logic [DvdW-1:0]   div_dividend, div_quo;
  logic [DvsW-1:0]   div_divisor;
  logic [CodeW-1:0]  diff;
  logic [SqRemW-1:0] sq_trial, sq_cand;
  logic              sq_ge, in_acc, out_load;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q  <= PressureZeroReset;
      scale_q <= SpeedScaleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRESSURE_ZERO: zero_q  <= cfg_data_i[CodeW-1:0];
        CFG_SPEED_SCALE:   scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pav_ram #(.Width(CodeW), .Depth(PRESSURE_WINDOW)) u_pring (
    .clk_i, .we_i(state_q == S_PUPD), .waddr_i(pslot_q), .wdata_i(code_q),
    .raddr_i(pslot_q), .rdata_o(prd)
  );

  pav_ram #(.Width(SpeedW), .Depth(SPEED_WINDOW)) u_sring (
    .clk_i, .we_i(state_q == S_SUPD), .waddr_i(sslot_q), .wdata_i(root_q),
    .raddr_i(sslot_q), .rdata_o(srd)
  );

  // running sums and warm-up divisors
  assign pnext    = PcW'(pslot_q) + 1'b1;
  assign snext    = ScW'(sslot_q) + 1'b1;
  assign pdivisor = pfilled_q ? PcW'(PRESSURE_WINDOW) : pnext;
  assign sdivisor = sfilled_q ? ScW'(SPEED_WINDOW) : snext;
  assign ptotal_d = ptotal_q - (pfilled_q ? PtW'(prd) : '0) + PtW'(code_q);
  assign stotal_d = stotal_q - (sfilled_q ? StW'(srd) : '0) + StW'(root_q);

  assign div_start    = (state_q == S_PUPD) || (state_q == S_SUPD);
  assign div_dividend = (state_q == S_PUPD) ? DvdW'(ptotal_d) : DvdW'(stotal_d);
  assign div_divisor  = (state_q == S_PUPD) ? DvsW'(pdivisor) : DvsW'(sdivisor);

  pav_div #(.DividendW(DvdW), .DivisorW(DvsW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dividend),
    .divisor_i(div_divisor), .busy_o(div_busy), .done_o(div_done),
    .quotient_o(div_quo)
  );

  // clamp below the zero point
  assign diff = (mp_q > zero_q) ? (mp_q - zero_q) : '0;

  // square root: two radicand bits per step
  assign sq_trial = {sq_rem_q[SqRemW-3:0], rad_q[ProdW-1 -: 2]};
  assign sq_cand  = {root_q[SqRemW-3:0], 2'b01};
  assign sq_ge    = sq_trial >= sq_cand;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_PUPD;
      S_PUPD: state_d = S_PDIV;
      S_PDIV: if (div_done) state_d = S_MUL;
      S_MUL:  state_d = S_SQRT;
      S_SQRT: if (sq_cnt_q == SqCntW'(SqrtSteps - 1)) state_d = S_SUPD;
      S_SUPD: state_d = S_SDIV;
      S_SDIV: if (div_done) state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptotal_q    <= '0;
      pslot_q     <= '0;
      pfilled_q   <= 1'b0;
      stotal_q    <= '0;
      sslot_q     <= '0;
      sfilled_q   <= 1'b0;
      sq_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // advance pressure window
      if (state_q == S_PUPD) begin
        ptotal_q <= ptotal_d;
        if (pnext == PcW'(PRESSURE_WINDOW)) begin
          pslot_q   <= '0;
          pfilled_q <= 1'b1;
        end else begin
          pslot_q <= pnext[PaW-1:0];
        end
      end
      // advance speed window
      if (state_q == S_SUPD) begin
        stotal_q <= stotal_d;
        if (snext == ScW'(SPEED_WINDOW)) begin
          sslot_q   <= '0;
          sfilled_q <= 1'b1;
        end else begin
          sslot_q <= snext[SaW-1:0];
        end
      end
      if (state_q == S_MUL) begin
        sq_cnt_q <= '0;
      end else if (state_q == S_SQRT) begin
        sq_cnt_q <= sq_cnt_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) code_q <= raw_reading_i[CodeW-1:0];
    if (state_q == S_PDIV && div_done) mp_q <= div_quo[CodeW-1:0];
    if (state_q == S_SDIV && div_done) ms_q <= div_quo[SpeedW-1:0];
    if (state_q == S_MUL) begin
      rad_q    <= diff * scale_q;
      sq_rem_q <= '0;
      root_q   <= '0;
    end else if (state_q == S_SQRT) begin
      rad_q    <= {rad_q[ProdW-3:0], 2'b00};
      sq_rem_q <= sq_ge ? (sq_trial - sq_cand) : sq_trial;
      root_q   <= {root_q[SpeedW-2:0], sq_ge};
    end
    if (out_load) begin
      out_mp_q <= mp_q;
      out_ms_q <= ms_q;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign mean_pressure_o = out_mp_q;
  assign mean_airspeed_o = out_ms_q;

  // checks
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_slots_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PcW'(pslot_q) < PcW'(PRESSURE_WINDOW)) && (ScW'(sslot_q) < ScW'(SPEED_WINDOW)))
    else $error("ring slot out of range");
  a_accept_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_PUPD) && !div_busy) else $error("accept did not start");
  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_busy) else $error("divider busy while idle");

endmodule
